[rtl/core/arp_reply_prefix_table_defines.svh]
// Assertion macros for the verification files of arp_reply_prefix_table.
// No dependencies; arpt_checker.sv includes this header.
`ifndef ARP_REPLY_PREFIX_TABLE_DEFINES_SVH
`define ARP_REPLY_PREFIX_TABLE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ARPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arpt assertion failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ARPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arpt assertion failed");

`endif

[rtl/core/arpt_pkg.sv]
// Package for the ARP reply prefix table: command/status structs, codes, constants.
// No dependencies; imported by arpt_ctrl, arpt_dpath and arp_reply_prefix_table.
package arpt_pkg;

    localparam int IN_DATA_W  = 280;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 168;
    localparam int OUT_USER_W = 2;

    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [13:0] MIN_ARP_FRAME = 14'd42;
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] HW_ETHERNET   = 16'h0001;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [5:0]  MAX_PFX_LEN   = 6'd32;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
        logic [47:0] mac;
    } t_slot;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic slot_free;
    } t_ctl_sts;

    function automatic logic [31:0] len_to_mask(input logic [5:0] len);
        logic [31:0] ones;
        ones = '1;
        if (len == 6'd0) begin
            return 32'd0;
        end
        return ones << (MAX_PFX_LEN - len);
    endfunction

endpackage

[rtl/core/arpt_ctrl.sv]
// Controller of the ARP reply prefix table: accepts an item, sweeps the table, commits.
// Depends on arpt_pkg; drives arpt_dpath through t_ctl_cmd and the read address.
module arpt_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IW = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output arpt_pkg::t_ctl_cmd o_cmd,
    output logic [IW-1:0]     o_rd_addr,
    input  arpt_pkg::t_ctl_sts i_sts
);
    import arpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);

    t_state        r_state;
    logic [IW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (i_sts.slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_rd_addr     = r_addr;
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd_en   = (r_state == S_SCAN);
    assign o_cmd.commit  = (r_state == S_COMMIT) && i_sts.slot_free;

endmodule

[rtl/core/arpt_dpath.sv]
// Datapath of the ARP reply prefix table: item register, slot memory, match tracking,
// result register. Depends on arpt_pkg; sequenced by arpt_ctrl.
module arpt_dpath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IW = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  arpt_pkg::t_ctl_cmd              i_cmd,
    input  logic [IW-1:0]                   i_rd_addr,
    output arpt_pkg::t_ctl_sts              o_sts,
    input  logic [arpt_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [arpt_pkg::IN_USER_W-1:0]  i_in_user,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [arpt_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic [arpt_pkg::OUT_USER_W-1:0] o_out_user
);
    import arpt_pkg::*;

    // item fields
    logic [1:0]  r_cmd;
    logic        r_hdr_ok;
    logic [47:0] r_smac;
    logic [31:0] r_sip;
    logic [31:0] r_tip;
    logic [31:0] r_pfx;
    logic [5:0]  r_len;
    logic [47:0] r_emac;

    logic [5:0]  n_len;
    logic        n_hdr_ok;

    always_comb begin
        n_len = (i_in_data[227:222] > MAX_PFX_LEN) ? MAX_PFX_LEN : i_in_data[227:222];
        n_hdr_ok = (i_in_data[13:0] >= MIN_ARP_FRAME) &&
                   (i_in_data[29:14] == ETH_TYPE_ARP) &&
                   (i_in_data[45:30] == HW_ETHERNET) &&
                   (i_in_data[61:46] == ETH_TYPE_IPV4) &&
                   (i_in_data[77:62] == OP_REQUEST);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_in_user;
            r_hdr_ok <= n_hdr_ok;
            r_smac   <= i_in_data[125:78];
            r_sip    <= i_in_data[157:126];
            r_tip    <= i_in_data[189:158];
            r_len    <= n_len;
            r_pfx    <= i_in_data[221:190] & len_to_mask(n_len);
            r_emac   <= i_in_data[275:228];
        end
    end

    // slot memory, registered read
    t_slot                     r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  r_valid;
    t_slot                     r_rd;
    logic                      r_beat;
    logic                      r_rd_vld;
    logic [IW-1:0]             r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_beat   <= i_cmd.rd_en;
            r_rd_vld <= r_valid[i_rd_addr];
            r_rd_idx <= i_rd_addr;
        end
    end

    // per-slot evaluation
    logic r_best_found;
    logic [5:0] r_best_len;
    logic [47:0] r_best_mac;
    logic r_match_found;
    logic [IW-1:0] r_match_idx;
    logic r_free_found;
    logic [IW-1:0] r_free_idx;

    logic lpm_take;
    logic exact_hit;

    always_comb begin
        lpm_take  = r_rd_vld &&
                    ((r_tip & len_to_mask(r_rd.len)) == r_rd.prefix) &&
                    (!r_best_found || (r_rd.len > r_best_len));
        exact_hit = r_rd_vld && (r_rd.prefix == r_pfx) && (r_rd.len == r_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found  <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else if (i_cmd.load) begin
            r_best_found  <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else if (r_beat) begin
            if (lpm_take) begin
                r_best_found <= 1'b1;
            end
            if (exact_hit && !r_match_found) begin
                r_match_found <= 1'b1;
            end
            if (!r_rd_vld && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_beat) begin
            if (lpm_take) begin
                r_best_len <= r_rd.len;
                r_best_mac <= r_rd.mac;
            end
            if (exact_hit && !r_match_found) begin
                r_match_idx <= r_rd_idx;
            end
            if (!r_rd_vld && !r_free_found) begin
                r_free_idx <= r_rd_idx;
            end
        end
    end

    // commit: table update and result
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic          clr_en;
    logic          hit;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [OUT_USER_W-1:0] n_out_user;

    always_comb begin
        wr_en      = 1'b0;
        clr_en     = 1'b0;
        wr_idx     = r_match_found ? r_match_idx : r_free_idx;
        hit        = r_hdr_ok && r_best_found;
        n_out_data = '0;
        n_out_user = '0;
        case (r_cmd)
            CMD_FRAME: begin
                n_out_user = {!hit, hit};
                if (hit) begin
                    n_out_data[47:0]    = r_smac;
                    n_out_data[95:48]   = r_best_mac;
                    n_out_data[127:96]  = r_tip;
                    n_out_data[159:128] = r_sip;
                end
            end
            CMD_ADD: begin
                if (r_match_found || r_free_found) begin
                    wr_en = i_cmd.commit;
                end else begin
                    n_out_data[161:160] = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (r_match_found) begin
                    clr_en = i_cmd.commit;
                end else begin
                    n_out_data[161:160] = ST_NOT_FOUND;
                end
            end
            default: begin
                n_out_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= '{prefix: r_pfx, len: r_len, mac: r_emac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_idx] <= 1'b1;
        end else if (clr_en) begin
            r_valid[r_match_idx] <= 1'b0;
        end
    end

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_out_user      = r_out_user;

endmodule

[rtl/core/arp_reply_prefix_table.sv]
// An item is taken in the idle state; the controller then scans each table slot, drains the
// last registered read and commits, stalling in commit while an earlier result is pending.
// The result register lets the next item be taken while a result waits for transfer.
// Reset (i_rst_n low, synchronous): table empty, controller idle, no result pending.
// Top level of the ARP reply prefix table; depends on arpt_pkg, arpt_ctrl, arpt_dpath.
module arp_reply_prefix_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // frame_len, eth_type, hw_type, proto_type, arp_op, sender_mac, sender_ip,
    // tgt_ip, entry_prefix, entry_len, entry_mac, zero pad
    input  logic [arpt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // cmd
    input  logic [arpt_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // reply_dst_mac, reply_src_mac, reply_sender_ip, reply_target_ip, status, zero pad
    output logic [arpt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // reply_valid, pass_through
    output logic [arpt_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import arpt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_ctl_cmd      ctl_cmd;
    t_ctl_sts      ctl_sts;
    logic [IW-1:0] rd_addr;

    arpt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (ctl_cmd),
        .o_rd_addr  (rd_addr),
        .i_sts      (ctl_sts)
    );

    arpt_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .i_rd_addr   (rd_addr),
        .o_sts       (ctl_sts),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule

[rtl/core/arpt_checker.sv]
// Port-level checks for arp_reply_prefix_table, bound to the top level.
// Depends on arpt_pkg and arp_reply_prefix_table_defines.svh.
`include "arp_reply_prefix_table_defines.svh"

module arpt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [arpt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [arpt_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import arpt_pkg::*;

    `ARPT_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    `ARPT_ASSERT_NEXT(a_in_busy, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    `ARPT_ASSERT_NOW(a_flags_excl, o_m_axis_tvalid, !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))

    `ARPT_ASSERT_NOW(a_no_reply_zero, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata[159:0] == 160'd0)

    `ARPT_ASSERT_NOW(a_frame_status_ok, o_m_axis_tvalid && (o_m_axis_tuser != 2'd0), o_m_axis_tdata[161:160] == ST_OK)

endmodule

bind arp_reply_prefix_table arpt_checker u_arpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[tb/sv/tb.sv]
// Testbench for arp_reply_prefix_table: prefix table edits, ARP request checks and
// longest-prefix replies, checked against an in-bench table model. Depends on arpt_pkg.
`timescale 1ns / 100ps

module tb;
    import arpt_pkg::*;

    localparam int          TABLE_ENTRIES = 16;
    localparam int          RAND_ITEMS    = 1600;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          DRAIN_CYCLES  = 40;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [13:0] frame_len;
        logic [15:0] eth_type;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] arp_op;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] tgt_ip;
        logic [31:0] entry_prefix;
        logic [5:0]  entry_len;
        logic [47:0] entry_mac;
    } t_arp_item;

    typedef struct packed {
        logic        reply_valid;
        logic        pass_through;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] sender_ip;
        logic [31:0] tgt_ip;
        logic [1:0]  status;
    } t_arp_result;

    typedef struct packed {
        t_arp_item   item;
        logic        typed;
        t_arp_result res;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // prefix table as the block should hold it
    logic        tbl_valid [TABLE_ENTRIES];
    logic [31:0] tbl_prefix[TABLE_ENTRIES];
    logic [5:0]  tbl_len   [TABLE_ENTRIES];
    logic [47:0] tbl_mac   [TABLE_ENTRIES];

    t_arp_result pending_replies[$];
    t_dir_row    dir_rows[$];
    int          fail_cnt = 0;
    int          rcv_cnt = 0;
    int          cycle_cnt = 0;

    arp_reply_prefix_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        if (len == 6'd0) begin
            return 32'd0;
        end
        return 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[47:0];
    endfunction

    // next result from the table, updating the table as the block would
    function automatic t_arp_result resolve_item(input t_arp_item it);
        t_arp_result res;
        logic [5:0]  len;
        logic [31:0] pfx;
        int          idx;
        int          best_len;
        res = '0;
        idx = -1;
        best_len = 0;
        case (it.cmd)
            CMD_FRAME: begin
                if (it.frame_len >= MIN_ARP_FRAME && it.eth_type == ETH_TYPE_ARP &&
                    it.hw_type == HW_ETHERNET && it.proto_type == ETH_TYPE_IPV4 &&
                    it.arp_op == OP_REQUEST) begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (tbl_valid[i] &&
                            (it.tgt_ip & prefix_mask(tbl_len[i])) == tbl_prefix[i] &&
                            (idx < 0 || int'(tbl_len[i]) > best_len)) begin
                            idx = i;
                            best_len = int'(tbl_len[i]);
                        end
                    end
                end
                if (idx >= 0) begin
                    res.reply_valid = 1'b1;
                    res.dst_mac     = it.sender_mac;
                    res.src_mac     = tbl_mac[idx];
                    res.sender_ip   = it.tgt_ip;
                    res.tgt_ip      = it.sender_ip;
                end else begin
                    res.pass_through = 1'b1;
                end
            end
            CMD_ADD, CMD_REMOVE: begin
                len = (it.entry_len > MAX_PFX_LEN) ? MAX_PFX_LEN : it.entry_len;
                pfx = it.entry_prefix & prefix_mask(len);
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (idx < 0 && tbl_valid[i] && tbl_prefix[i] == pfx && tbl_len[i] == len) begin
                        idx = i;
                    end
                end
                if (it.cmd == CMD_ADD) begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (idx < 0 && !tbl_valid[i]) begin
                            idx = i;
                        end
                    end
                    if (idx < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        tbl_valid[idx]  = 1'b1;
                        tbl_prefix[idx] = pfx;
                        tbl_len[idx]    = len;
                        tbl_mac[idx]    = it.entry_mac;
                    end
                end else if (idx < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    tbl_valid[idx] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_arp_item rand_fields(input logic [1:0] cmd);
        t_arp_item it;
        it.cmd          = cmd;
        it.frame_len    = 14'($urandom_range(0, 16383));
        it.eth_type     = 16'($urandom_range(0, 65535));
        it.hw_type      = 16'($urandom_range(0, 65535));
        it.proto_type   = 16'($urandom_range(0, 65535));
        it.arp_op       = 16'($urandom_range(0, 65535));
        it.sender_mac   = rand_mac();
        it.sender_ip    = $urandom;
        it.tgt_ip       = $urandom;
        it.entry_prefix = $urandom;
        it.entry_len    = 6'($urandom_range(0, 63));
        it.entry_mac    = rand_mac();
        return it;
    endfunction

    function automatic t_arp_item mk_frame(input logic [13:0] flen, input logic [15:0] et,
                                           input logic [15:0] hw, input logic [15:0] pt,
                                           input logic [15:0] op, input logic [47:0] smac,
                                           input logic [31:0] sip, input logic [31:0] tip);
        t_arp_item it;
        it            = '0;
        it.cmd        = CMD_FRAME;
        it.frame_len  = flen;
        it.eth_type   = et;
        it.hw_type    = hw;
        it.proto_type = pt;
        it.arp_op     = op;
        it.sender_mac = smac;
        it.sender_ip  = sip;
        it.tgt_ip     = tip;
        return it;
    endfunction

    function automatic t_arp_item mk_request(input logic [31:0] tip);
        return mk_frame(14'd60, ETH_TYPE_ARP, HW_ETHERNET, ETH_TYPE_IPV4, OP_REQUEST,
                        48'h0200_1122_3344, 32'hC0A8_0001, tip);
    endfunction

    function automatic t_arp_item mk_entry(input logic [1:0] cmd, input logic [31:0] pfx,
                                           input logic [5:0] len, input logic [47:0] mac);
        t_arp_item it;
        it              = '0;
        it.cmd          = cmd;
        it.entry_prefix = pfx;
        it.entry_len    = len;
        it.entry_mac    = mac;
        return it;
    endfunction

    function automatic t_arp_result res_pass();
        t_arp_result res;
        res = '0;
        res.pass_through = 1'b1;
        return res;
    endfunction

    function automatic t_arp_result res_status(input logic [1:0] st);
        t_arp_result res;
        res = '0;
        res.status = st;
        return res;
    endfunction

    function automatic void add_row(input t_arp_item it, input logic typed,
                                    input t_arp_result res);
        t_dir_row row;
        row.item  = it;
        row.typed = typed;
        row.res   = res;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic int pick_live_slot();
        int n;
        int k;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                n++;
            end
        end
        if (n == 0) begin
            return -1;
        end
        k = int'($urandom_range(0, n - 1));
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (k == 0) begin
                    return i;
                end
                k--;
            end
        end
        return -1;
    endfunction

    function automatic logic [5:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 6'd0;
        end else if (r < 25) begin
            return 6'd32;
        end else if (r < 35) begin
            return 6'($urandom_range(33, 63));
        end
        return 6'($urandom_range(1, 31));
    endfunction

    function automatic logic [31:0] rand_prefix();
        logic [31:0] p;
        p = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            p[31:24] = 8'h0A;
        end
        return p;
    endfunction

    // phase 0 mixed, 1 mostly adds (fills the table), 2 mostly removes
    function automatic t_arp_item gen_item(input int phase);
        t_arp_item   it;
        int          r;
        int          s;
        int          t_frame;
        int          t_add;
        int          t_rem;
        logic [31:0] m;
        t_frame = (phase == 0) ? 45 : 35;
        t_add   = t_frame + ((phase == 0) ? 22 : (phase == 1) ? 50 : 8);
        t_rem   = t_add + ((phase == 0) ? 22 : (phase == 1) ? 8 : 50);
        r = $urandom_range(0, 99);
        if (r < t_frame) begin
            it = rand_fields(CMD_FRAME);
            r = $urandom_range(0, 99);
            if (r < 75) begin
                it.frame_len  = ($urandom_range(0, 9) == 0) ? MIN_ARP_FRAME :
                                14'($urandom_range(42, 16383));
                it.eth_type   = ETH_TYPE_ARP;
                it.hw_type    = HW_ETHERNET;
                it.proto_type = ETH_TYPE_IPV4;
                it.arp_op     = OP_REQUEST;
            end else begin
                it.eth_type   = ETH_TYPE_ARP;
                it.hw_type    = HW_ETHERNET;
                it.proto_type = ETH_TYPE_IPV4;
                it.arp_op     = OP_REQUEST;
                case ($urandom_range(0, 4))
                    0: it.frame_len  = 14'($urandom_range(0, 41));
                    1: it.eth_type   = 16'($urandom_range(0, 65535));
                    2: it.hw_type    = 16'($urandom_range(0, 65535));
                    3: it.proto_type = 16'($urandom_range(0, 65535));
                    default: it.arp_op = 16'($urandom_range(0, 65535));
                endcase
            end
            s = pick_live_slot();
            if (s >= 0 && $urandom_range(0, 9) < 7) begin
                m = prefix_mask(tbl_len[s]);
                it.tgt_ip = (tbl_prefix[s] & m) | ($urandom & ~m);
            end else if ($urandom_range(0, 1) == 0) begin
                it.tgt_ip[31:24] = 8'h0A;
            end
        end else if (r < t_add) begin
            it = rand_fields(CMD_ADD);
            s = pick_live_slot();
            if (s >= 0 && $urandom_range(0, 4) == 0) begin
                m = prefix_mask(tbl_len[s]);
                it.entry_prefix = tbl_prefix[s] | ($urandom & ~m);
                it.entry_len    = tbl_len[s];
            end else begin
                it.entry_prefix = rand_prefix();
                it.entry_len    = rand_len();
            end
        end else if (r < t_rem) begin
            it = rand_fields(CMD_REMOVE);
            s = pick_live_slot();
            if (s >= 0 && $urandom_range(0, 9) < 7) begin
                m = prefix_mask(tbl_len[s]);
                it.entry_prefix = tbl_prefix[s] | ($urandom & ~m);
                it.entry_len    = (tbl_len[s] == MAX_PFX_LEN && $urandom_range(0, 1) == 0) ?
                                  6'($urandom_range(33, 63)) : tbl_len[s];
            end else begin
                it.entry_prefix = rand_prefix();
                it.entry_len    = rand_len();
            end
        end else if (r < t_rem + 2) begin
            it = rand_fields(CMD_UNUSED);
        end else begin
            it = rand_fields(2'($urandom_range(0, 3)));
        end
        return it;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input t_arp_item it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {4'd0, it.entry_mac, it.entry_len, it.entry_prefix, it.tgt_ip,
                     it.sender_ip, it.sender_mac, it.arp_op, it.proto_type, it.hw_type,
                     it.eth_type, it.frame_len};
        do begin
            @(posedge i_clk);
        end while (!s_tready);
    endtask

    task automatic idle_sender(input bit quiet);
        int g;
        g = quiet ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic check_result();
        t_arp_result got;
        t_arp_result want;
        got.reply_valid  = m_tuser[0];
        got.pass_through = m_tuser[1];
        got.dst_mac      = m_tdata[47:0];
        got.src_mac      = m_tdata[95:48];
        got.sender_ip    = m_tdata[127:96];
        got.tgt_ip       = m_tdata[159:128];
        got.status       = m_tdata[161:160];
        rcv_cnt++;
        if (pending_replies.size() == 0) begin
            if (fail_cnt < 10) begin
                $display("result %0d with nothing outstanding: %p", rcv_cnt, got);
            end
            fail_cnt++;
        end else begin
            want = pending_replies.pop_front();
            if (got.reply_valid !== want.reply_valid || got.pass_through !== want.pass_through ||
                got.dst_mac !== want.dst_mac || got.src_mac !== want.src_mac ||
                got.sender_ip !== want.sender_ip || got.tgt_ip !== want.tgt_ip ||
                got.status !== want.status) begin
                if (fail_cnt < 10) begin
                    $display("result %0d mismatch\n  exp %p\n  got %p", rcv_cnt, want, got);
                end
                fail_cnt++;
            end
        end
    endtask

    // result side: random stalls, one long hold-off, one stretch without stalls
    initial begin
        int  hold;
        int  g;
        bit  long_done;
        hold = 0;
        long_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                check_result();
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!long_done && rcv_cnt >= 150) begin
                long_done = 1'b1;
                hold = 500;
                m_tready <= 1'b0;
            end else if (rcv_cnt >= 300 && rcv_cnt < 400) begin
                m_tready <= 1'b1;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    hold = g - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        t_arp_result res;
        t_arp_item   it;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_prefix[i] = '0;
            tbl_len[i]    = '0;
            tbl_mac[i]    = '0;
        end

        // empty table, then nested prefixes, header checks, removes
        add_row(mk_request(32'h0A01_0203), 1'b1, res_pass());
        add_row(mk_entry(CMD_REMOVE, 32'h0A00_0000, 6'd8, '0), 1'b1, res_status(ST_NOT_FOUND));
        it = '1;
        it.cmd = CMD_UNUSED;
        add_row(it, 1'b1, '0);
        add_row(mk_entry(CMD_ADD, 32'h0000_0000, 6'd0, 48'h0200_0000_0000), 1'b1,
                res_status(ST_OK));
        add_row(mk_entry(CMD_ADD, 32'h0A00_0000, 6'd8, 48'h0200_0000_0008), 1'b1,
                res_status(ST_OK));
        add_row(mk_entry(CMD_ADD, 32'h0A0B_FFFF, 6'd16, 48'h0200_0000_0016), 1'b0, '0);
        add_row(mk_entry(CMD_ADD, 32'hFFFF_FFFF, 6'd63, 48'hFFFF_FFFF_FFFF), 1'b0, '0);
        add_row(mk_entry(CMD_ADD, 32'h0A0B_0C0D, 6'd32, 48'h0200_0000_0032), 1'b0, '0);
        add_row(mk_entry(CMD_ADD, 32'h0A12_3456, 6'd8, 48'h0200_0000_0108), 1'b1,
                res_status(ST_OK));
        add_row(mk_request(32'h0A0B_0C0D), 1'b0, '0);
        add_row(mk_request(32'h0A0B_0101), 1'b0, '0);
        add_row(mk_request(32'h0A01_0203), 1'b0, '0);
        add_row(mk_request(32'h0102_0304), 1'b0, '0);
        add_row(mk_frame(14'd60, ETH_TYPE_ARP, HW_ETHERNET, ETH_TYPE_IPV4, OP_REQUEST,
                         48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(mk_frame(14'd41, ETH_TYPE_ARP, HW_ETHERNET, ETH_TYPE_IPV4, OP_REQUEST,
                         48'h0200_1122_3344, 32'hC0A8_0001, 32'h0A0B_0C0D), 1'b1, res_pass());
        add_row(mk_frame(MIN_ARP_FRAME, ETH_TYPE_ARP, HW_ETHERNET, ETH_TYPE_IPV4, OP_REQUEST,
                         48'h0000_0000_0000, 32'h0000_0000, 32'h0A0B_0C0D), 1'b0, '0);
        add_row(mk_frame(14'd16383, ETH_TYPE_ARP, HW_ETHERNET, ETH_TYPE_IPV4, OP_REQUEST,
                         48'h0200_1122_3344, 32'hC0A8_0001, 32'h0A0B_0102), 1'b0, '0);
        add_row(mk_frame(14'd60, ETH_TYPE_IPV4, HW_ETHERNET, ETH_TYPE_IPV4, OP_REQUEST,
                         48'h0200_1122_3344, 32'hC0A8_0001, 32'h0A0B_0C0D), 1'b1, res_pass());
        add_row(mk_frame(14'd60, ETH_TYPE_ARP, 16'hFFFF, ETH_TYPE_IPV4, OP_REQUEST,
                         48'h0200_1122_3344, 32'hC0A8_0001, 32'h0A0B_0C0D), 1'b1, res_pass());
        add_row(mk_frame(14'd60, ETH_TYPE_ARP, HW_ETHERNET, 16'h86DD, OP_REQUEST,
                         48'h0200_1122_3344, 32'hC0A8_0001, 32'h0A0B_0C0D), 1'b1, res_pass());
        add_row(mk_frame(14'd60, ETH_TYPE_ARP, HW_ETHERNET, ETH_TYPE_IPV4, 16'd2,
                         48'h0200_1122_3344, 32'hC0A8_0001, 32'h0A0B_0C0D), 1'b1, res_pass());
        add_row(mk_entry(CMD_REMOVE, 32'hFFFF_FFFF, 6'd32, '0), 1'b1, res_status(ST_OK));
        add_row(mk_entry(CMD_REMOVE, 32'h0AFF_FFFF, 6'd8, '0), 1'b1, res_status(ST_OK));
        add_row(mk_entry(CMD_REMOVE, 32'hDEAD_BEEF, 6'd0, '0), 1'b1, res_status(ST_OK));
        add_row(mk_request(32'h0102_0304), 1'b1, res_pass());

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item);
            res = resolve_item(dir_rows[i].item);
            pending_replies.insert(pending_replies.size(),
                                   dir_rows[i].typed ? dir_rows[i].res : res);
            idle_sender(1'b0);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            it = gen_item((n / 150) % 3);
            send_item(it);
            pending_replies.insert(pending_replies.size(), resolve_item(it));
            idle_sender(((n / 100) % 5) == 4);
        end
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && pending_replies.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
